// ===== src/p1305_pkg.sv =====
// Shared types and constants for the Poly1305 authenticator.
// No dependencies; imported by every module of the block.
package p1305_pkg;

  localparam int LIMB_W = 26;
  localparam int NLIMB = 5;
  localparam int SUM_W = 27;
  localparam int R5_W = 29;
  localparam int PROD_W = SUM_W + R5_W;
  localparam int ACC_W = 60;

  localparam logic [63:0] CLAMP_LO = 64'h0ffffffc0fffffff;
  localparam logic [63:0] CLAMP_HI = 64'h0ffffffc0ffffffc;

  localparam logic [1:0] REG_R_LOW = 2'd0;
  localparam logic [1:0] REG_R_HIGH = 2'd1;
  localparam logic [1:0] REG_S_LOW = 2'd2;
  localparam logic [1:0] REG_S_HIGH = 2'd3;

  typedef logic [LIMB_W-1:0] limb_t;
  typedef logic [SUM_W-1:0] sum_limb_t;
  typedef logic [R5_W-1:0] r5_limb_t;
  typedef logic [ACC_W-1:0] dacc_t;

endpackage

// ===== src/poly1305_mac.sv =====
// Poly1305 authenticator top level: key registers, accumulator and sequencer.
// Uses p1305_pkg, p1305_pad and p1305_mul.
// A block runs 25 multiply steps on one multiplier, then 15 carry steps; a last
// block adds a final reduction step and a tag step.
// A new block is accepted only in the idle state, once the previous one is done;
// an empty block that is not last needs no steps. A stalled tag holds the final step.
// Synchronous reset clears key registers, accumulator and the output transaction.
module poly1305_mac import p1305_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] block_low,
  input  logic [63:0] block_high,
  input  logic [4:0]  valid_bytes,
  input  logic        is_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] tag_low,
  output logic [63:0] tag_high
);

  typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_CARRY, ST_FIN1, ST_FIN2} state_t;

  state_t   state;
  logic [63:0] r_low, r_high, s_low, s_high;
  limb_t    acc [NLIMB];
  sum_limb_t a_limb [NLIMB];
  dacc_t    d [NLIMB];
  logic [2:0] cnt_i, cnt_j, cnt_k;
  logic [1:0] pass;
  logic     last;
  logic [127:0] hr;

  limb_t    m_limb [NLIMB];
  limb_t    r_limb [NLIMB];
  r5_limb_t r5_limb [NLIMB];
  logic [127:0] rc;
  logic [3:0] kdiff;
  logic [2:0] ksel;
  r5_limb_t rsel;
  logic [PROD_W-1:0] prod;
  logic [129:0] hpack;
  logic [130:0] gsum;
  logic [33:0] carry;
  logic [2:0] k_next;

  p1305_pad u_pad (
    .block_low  (block_low),
    .block_high (block_high),
    .valid_bytes(valid_bytes),
    .m_limb     (m_limb)
  );

  always_comb begin
    rc = {r_high & CLAMP_HI, r_low & CLAMP_LO};
    for (int k = 0; k < NLIMB - 1; k++) begin
      r_limb[k] = rc[LIMB_W*k +: LIMB_W];
    end
    r_limb[NLIMB-1] = limb_t'(rc[127:104]);
    for (int k = 0; k < NLIMB; k++) begin
      r5_limb[k] = (R5_W'(r_limb[k]) << 2) + R5_W'(r_limb[k]);
    end
    kdiff = 4'(cnt_i) + 4'd5 - 4'(cnt_j);
    ksel = (kdiff >= 4'd5) ? 3'(kdiff - 4'd5) : kdiff[2:0];
    rsel = (cnt_j > cnt_i) ? r5_limb[ksel] : R5_W'(r_limb[ksel]);
    hpack = {acc[4], acc[3], acc[2], acc[1], acc[0]};
    gsum = 131'(hpack) + 131'd5;
    carry = 34'(d[cnt_k] >> LIMB_W);
    k_next = cnt_k + 3'd1;
  end

  p1305_mul u_mul (
    .a(a_limb[cnt_j]),
    .b(rsel),
    .p(prod)
  );

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      r_low <= '0;
      r_high <= '0;
      s_low <= '0;
      s_high <= '0;
      for (int k = 0; k < NLIMB; k++) begin
        acc[k] <= '0;
      end
      cnt_i <= '0;
      cnt_j <= '0;
      cnt_k <= '0;
      pass <= '0;
      last <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_R_LOW:  r_low <= cfg_data;
          REG_R_HIGH: r_high <= cfg_data;
          REG_S_LOW:  s_low <= cfg_data;
          REG_S_HIGH: s_high <= cfg_data;
          default: ;
        endcase
      end
      if (state == ST_FIN2 && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            last <= is_last;
            cnt_i <= '0;
            cnt_j <= '0;
            for (int k = 0; k < NLIMB; k++) begin
              a_limb[k] <= SUM_W'(acc[k]) + SUM_W'(m_limb[k]);
              d[k] <= '0;
            end
            if (valid_bytes != 5'd0) begin
              state <= ST_MUL;
            end else if (is_last) begin
              state <= ST_FIN1;
            end
          end
        end
        ST_MUL: begin
          d[cnt_i] <= d[cnt_i] + ACC_W'(prod);
          if (cnt_j == 3'd4) begin
            cnt_j <= '0;
            if (cnt_i == 3'd4) begin
              cnt_k <= '0;
              pass <= '0;
              state <= ST_CARRY;
            end else begin
              cnt_i <= cnt_i + 3'd1;
            end
          end else begin
            cnt_j <= cnt_j + 3'd1;
          end
        end
        ST_CARRY: begin
          d[cnt_k] <= ACC_W'(d[cnt_k][LIMB_W-1:0]);
          if (cnt_k == 3'd4) begin
            d[0] <= d[0] + (ACC_W'(carry) << 2) + ACC_W'(carry);
            cnt_k <= '0;
            if (pass == 2'd2) begin
              for (int k = 1; k < NLIMB; k++) begin
                acc[k] <= d[k][LIMB_W-1:0];
              end
              acc[0] <= limb_t'(d[0][LIMB_W-1:0] + (ACC_W'(carry) << 2) + ACC_W'(carry));
              state <= last ? ST_FIN1 : ST_IDLE;
            end else begin
              pass <= pass + 2'd1;
            end
          end else begin
            d[k_next] <= d[k_next] + ACC_W'(carry);
            cnt_k <= k_next;
          end
        end
        ST_FIN1: begin
          hr <= gsum[130] ? gsum[127:0] : hpack[127:0];
          for (int k = 0; k < NLIMB; k++) begin
            acc[k] <= '0;
          end
          state <= ST_FIN2;
        end
        ST_FIN2: begin
          if (!out_valid || out_ready) begin
            {tag_high, tag_low} <= hr + {s_high, s_low};
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_busy_mul: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL || state == ST_CARRY) |-> !in_ready)
    else $error("input accepted during block processing");

  a_acc_cleared: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (hpack == '0))
    else $error("accumulator not cleared after tag");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (cnt_i <= 3'd4) && (cnt_j <= 3'd4) && (cnt_k <= 3'd4))
    else $error("limb index out of range");

  a_tag_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FIN2)
    else $error("tag transaction without final reduction");

endmodule

// ===== src/p1305_pad.sv =====
// Message block padding and split into 26-bit limbs.
// Depends on p1305_pkg.
module p1305_pad import p1305_pkg::*; (
  input  logic [63:0] block_low,
  input  logic [63:0] block_high,
  input  logic [4:0]  valid_bytes,
  output limb_t       m_limb [NLIMB]
);

  logic [4:0]   nc;
  logic [127:0] raw;
  logic [128:0] m;

  always_comb begin
    nc = (valid_bytes > 5'd16) ? 5'd16 : valid_bytes;
    raw = {block_high, block_low};
    m = '0;
    for (int b = 0; b < 16; b++) begin
      if (5'(b) < nc) begin
        m[8*b +: 8] = raw[8*b +: 8];
      end else if (5'(b) == nc) begin
        m[8*b +: 8] = 8'h01;
      end
    end
    m[128] = (nc == 5'd16);
    for (int k = 0; k < NLIMB - 1; k++) begin
      m_limb[k] = m[LIMB_W*k +: LIMB_W];
    end
    m_limb[NLIMB-1] = limb_t'(m[128:104]);
  end

endmodule

// ===== src/p1305_mul.sv =====
// Shared limb multiplier: one 27 by 29 bit product per cycle.
// Depends on p1305_pkg.
module p1305_mul import p1305_pkg::*; (
  input  sum_limb_t          a,
  input  r5_limb_t           b,
  output logic [PROD_W-1:0]  p
);

  assign p = PROD_W'(a) * PROD_W'(b);

endmodule
